@@ rtl/orpg_pkg.sv @@
// Shared types, constants and the control program of the open-loop ramp phase generator.
package orpg_pkg;

   // radians to turns: round(2^32 / (2*pi))
   localparam logic [29:0] TURN_PER_RAD = 30'd683565276;
   localparam logic [31:0] TICK_RATE_RESET = 32'd1000000;
   localparam int unsigned PC_WIDTH = 4;
   localparam int unsigned DIV_BITS = 32;

   // request and response payloads
   typedef struct packed {
      logic        action;
      logic [63:0] timestamp;
   } req_type;

   typedef struct packed {
      logic signed [31:0] current_out;
      logic signed [31:0] voltage_out;
      logic signed [31:0] velocity_out;
      logic signed [31:0] phase_out;
   } rsp_type;

   // action codes
   localparam logic ACTION_UPDATE = 1'b0;
   localparam logic ACTION_CLEAR  = 1'b1;

   // configuration registers
   typedef enum logic [2:0] {
      REG_CURRENT_GOAL  = 3'd0,
      REG_VOLTAGE_GOAL  = 3'd1,
      REG_VELOCITY_GOAL = 3'd2,
      REG_CURRENT_SLEW  = 3'd3,
      REG_VOLTAGE_SLEW  = 3'd4,
      REG_VELOCITY_SLEW = 3'd5,
      REG_START_PHASE   = 3'd6,
      REG_TICK_RATE     = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [31:0] current_goal;
      logic signed [31:0] voltage_goal;
      logic signed [31:0] velocity_goal;
      logic [30:0]        current_slew;
      logic [30:0]        voltage_slew;
      logic [30:0]        velocity_slew;
      logic signed [31:0] start_phase;
      logic [31:0]        tick_rate;
   } cfg_type;

   // control word fields
   typedef enum logic [2:0] {
      WB_NONE,
      WB_DIV_INIT,
      WB_DIV_STEP,
      WB_CURRENT,
      WB_VOLTAGE,
      WB_VELOCITY,
      WB_PART,
      WB_PUBLISH
   } wb_type;

   typedef enum logic [2:0] {
      MUL_HOLD,
      MUL_CURRENT,
      MUL_VOLTAGE,
      MUL_VELOCITY,
      MUL_TURN,
      MUL_PHASE_HI,
      MUL_PHASE_LO
   } mul_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_NOT_UPDATE,
      COND_SAT,
      COND_DIV_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      logic                wait_req;
      wb_type              wb;
      mul_type             mul;
      cond_type            cond;
      logic [PC_WIDTH-1:0] target;
      logic                last;
   } ctrl_type;

   // status fed back to the sequencer
   typedef struct packed {
      logic update;
      logic sat;
      logic div_more;
      logic out_busy;
   } stat_type;

   typedef struct packed {
      logic sat;
      logic div_more;
   } flags_type;

   // program addresses
   localparam logic [PC_WIDTH-1:0] STEP_WAIT     = 4'd0;
   localparam logic [PC_WIDTH-1:0] STEP_DIV_INIT = 4'd1;
   localparam logic [PC_WIDTH-1:0] STEP_DIV      = 4'd2;
   localparam logic [PC_WIDTH-1:0] STEP_MUL_CUR  = 4'd3;
   localparam logic [PC_WIDTH-1:0] STEP_CLAMP_C  = 4'd4;
   localparam logic [PC_WIDTH-1:0] STEP_CLAMP_V  = 4'd5;
   localparam logic [PC_WIDTH-1:0] STEP_CLAMP_W  = 4'd6;
   localparam logic [PC_WIDTH-1:0] STEP_TURN     = 4'd7;
   localparam logic [PC_WIDTH-1:0] STEP_PH_HI    = 4'd8;
   localparam logic [PC_WIDTH-1:0] STEP_PH_LO    = 4'd9;
   localparam logic [PC_WIDTH-1:0] STEP_PUBLISH  = 4'd10;

   function automatic ctrl_type make_word(logic wait_req, wb_type wb, mul_type mul,
                                          cond_type cond, logic [PC_WIDTH-1:0] target,
                                          logic last);
      ctrl_type w;
      w.wait_req = wait_req;
      w.wb       = wb;
      w.mul      = mul;
      w.cond     = cond;
      w.target   = target;
      w.last     = last;
      return w;
   endfunction

   // control store
   function automatic ctrl_type program_word(logic [PC_WIDTH-1:0] pc);
      ctrl_type w;
      unique case (pc)
         STEP_WAIT:     w = make_word(1'b1, WB_NONE, MUL_HOLD, COND_NOT_UPDATE, STEP_WAIT, 1'b0);
         STEP_DIV_INIT: w = make_word(1'b0, WB_DIV_INIT, MUL_HOLD, COND_SAT, STEP_MUL_CUR, 1'b0);
         STEP_DIV:      w = make_word(1'b0, WB_DIV_STEP, MUL_HOLD, COND_DIV_MORE, STEP_DIV, 1'b0);
         STEP_MUL_CUR:  w = make_word(1'b0, WB_NONE, MUL_CURRENT, COND_NONE, STEP_WAIT, 1'b0);
         STEP_CLAMP_C:  w = make_word(1'b0, WB_CURRENT, MUL_VOLTAGE, COND_NONE, STEP_WAIT, 1'b0);
         STEP_CLAMP_V:  w = make_word(1'b0, WB_VOLTAGE, MUL_VELOCITY, COND_NONE, STEP_WAIT, 1'b0);
         STEP_CLAMP_W:  w = make_word(1'b0, WB_VELOCITY, MUL_HOLD, COND_NONE, STEP_WAIT, 1'b0);
         STEP_TURN:     w = make_word(1'b0, WB_NONE, MUL_TURN, COND_NONE, STEP_WAIT, 1'b0);
         STEP_PH_HI:    w = make_word(1'b0, WB_PART, MUL_PHASE_HI, COND_NONE, STEP_WAIT, 1'b0);
         STEP_PH_LO:    w = make_word(1'b0, WB_PART, MUL_PHASE_LO, COND_NONE, STEP_WAIT, 1'b0);
         STEP_PUBLISH:  w = make_word(1'b0, WB_PUBLISH, MUL_HOLD, COND_OUT_BUSY, STEP_PUBLISH,
                                      1'b1);
         default:       w = make_word(1'b0, WB_NONE, MUL_HOLD, COND_NONE, STEP_WAIT, 1'b1);
      endcase
      return w;
   endfunction

endpackage

@@ rtl/orpg_sequencer.sv @@
// Step counter and control store of the ramp phase generator.
module orpg_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  orpg_pkg::stat_type stat,
   output orpg_pkg::ctrl_type ctrl
);

   logic [orpg_pkg::PC_WIDTH-1:0] pc_ff;
   logic [orpg_pkg::PC_WIDTH-1:0] pc_in;
   logic                          taken;

   assign ctrl = orpg_pkg::program_word(pc_ff);

   // jump condition
   always_comb begin
      unique case (ctrl.cond)
         orpg_pkg::COND_NONE:       taken = 1'b0;
         orpg_pkg::COND_NOT_UPDATE: taken = !stat.update;
         orpg_pkg::COND_SAT:        taken = stat.sat;
         orpg_pkg::COND_DIV_MORE:   taken = stat.div_more;
         orpg_pkg::COND_OUT_BUSY:   taken = stat.out_busy;
         default:                   taken = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      if (taken) begin
         pc_in = ctrl.target;
      end else if (ctrl.last) begin
         pc_in = orpg_pkg::STEP_WAIT;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= orpg_pkg::STEP_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

@@ rtl/orpg_datapath.sv @@
// Datapath: held values, elapsed-time divider, shared multiplier, slew clamp and phase sum.
module orpg_datapath (
   input  logic                clock,
   input  logic                reset,
   input  orpg_pkg::cfg_type   cfg,
   input  orpg_pkg::ctrl_type  ctrl,
   input  logic                accept,
   input  orpg_pkg::req_type   req,
   input  logic                out_busy,
   output orpg_pkg::flags_type flags,
   output orpg_pkg::rsp_type   result
);

   // held state
   logic               held_valid_ff;
   logic [63:0]        last_time_ff;
   logic signed [31:0] held_current_ff;
   logic signed [31:0] held_voltage_ff;
   logic signed [31:0] held_velocity_ff;
   logic signed [31:0] held_phase_ff;

   // working registers
   logic [63:0] diff_ff;
   logic [31:0] rem_ff;
   logic [31:0] quot_ff;
   logic [4:0]  count_ff;
   logic [63:0] mul_ff;
   logic [31:0] part_ff;

   logic [31:0]        rate;
   logic [32:0]        rem_shift;
   logic               rem_ge;
   logic [32:0]        rem_diff;
   logic [31:0]        rem_in;
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] mul_prod;
   logic signed [31:0] goal;
   logic signed [31:0] prev;
   logic signed [31:0] clamp_in;
   logic [31:0]        phase_in;
   logic               publish;

   // move prev toward goal by at most step
   function automatic logic [31:0] slew_toward(logic signed [31:0] p_val,
                                               logic signed [31:0] g_val,
                                               logic [46:0] step);
      logic signed [48:0] p;
      logic signed [48:0] g;
      logic signed [48:0] st;
      logic signed [48:0] lo;
      logic signed [48:0] hi;
      logic signed [48:0] r;
      p  = {{17{p_val[31]}}, p_val};
      g  = {{17{g_val[31]}}, g_val};
      st = {2'b00, step};
      lo = p - st;
      hi = p + st;
      if (g < lo) begin
         r = lo;
      end else if (g > hi) begin
         r = hi;
      end else begin
         r = g;
      end
      return r[31:0];
   endfunction

   // divider: zero rate counts as one
   assign rate       = (cfg.tick_rate == 32'd0) ? 32'd1 : cfg.tick_rate;
   assign flags.sat  = diff_ff >= {16'h0000, rate, 16'h0000};
   assign flags.div_more = count_ff != 5'd0;
   assign rem_shift  = {rem_ff, quot_ff[31]};
   assign rem_diff   = rem_shift - {1'b0, rate};
   assign rem_ge     = rem_shift >= {1'b0, rate};
   assign rem_in     = rem_ge ? rem_diff[31:0] : rem_shift[31:0];

   // shared multiplier operands
   always_comb begin
      case (ctrl.mul)
         orpg_pkg::MUL_CURRENT: begin
            mul_a = {2'b00, cfg.current_slew};
            mul_b = {1'b0, quot_ff};
         end
         orpg_pkg::MUL_VOLTAGE: begin
            mul_a = {2'b00, cfg.voltage_slew};
            mul_b = {1'b0, quot_ff};
         end
         orpg_pkg::MUL_VELOCITY: begin
            mul_a = {2'b00, cfg.velocity_slew};
            mul_b = {1'b0, quot_ff};
         end
         orpg_pkg::MUL_TURN: begin
            mul_a = {held_velocity_ff[31], held_velocity_ff};
            mul_b = {1'b0, quot_ff};
         end
         orpg_pkg::MUL_PHASE_HI: begin
            mul_a = {1'b0, mul_ff[63:32]};
            mul_b = {3'b000, orpg_pkg::TURN_PER_RAD};
         end
         orpg_pkg::MUL_PHASE_LO: begin
            mul_a = {1'b0, part_ff};
            mul_b = {3'b000, orpg_pkg::TURN_PER_RAD};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_prod = mul_a * mul_b;

   // clamp operand select
   always_comb begin
      case (ctrl.wb)
         orpg_pkg::WB_VOLTAGE: begin
            prev = held_voltage_ff;
            goal = cfg.voltage_goal;
         end
         orpg_pkg::WB_VELOCITY: begin
            prev = held_velocity_ff;
            goal = cfg.velocity_goal;
         end
         default: begin
            prev = held_current_ff;
            goal = cfg.current_goal;
         end
      endcase
   end

   assign clamp_in = slew_toward(prev, goal, mul_ff[62:16]);

   // phase: hi*K low word + lo*K high word, added to the held phase
   assign phase_in = held_phase_ff + part_ff + mul_ff[63:32];
   assign publish  = (ctrl.wb == orpg_pkg::WB_PUBLISH) && !out_busy;

   assign result.current_out  = held_current_ff;
   assign result.voltage_out  = held_voltage_ff;
   assign result.velocity_out = held_velocity_ff;
   assign result.phase_out    = phase_in;

   // control-like state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         last_time_ff  <= '0;
      end else if (accept) begin
         if (req.action == orpg_pkg::ACTION_CLEAR) begin
            held_valid_ff <= 1'b0;
         end else begin
            held_valid_ff <= 1'b1;
            last_time_ff  <= req.timestamp;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         diff_ff <= req.timestamp - last_time_ff;
         if ((req.action == orpg_pkg::ACTION_CLEAR) || !held_valid_ff) begin
            held_current_ff  <= '0;
            held_voltage_ff  <= '0;
            held_velocity_ff <= '0;
            held_phase_ff    <= (req.action == orpg_pkg::ACTION_CLEAR) ? 32'sd0
                                                                      : cfg.start_phase;
         end
      end

      if (ctrl.mul != orpg_pkg::MUL_HOLD) begin
         mul_ff <= mul_prod[63:0];
      end

      case (ctrl.wb)
         orpg_pkg::WB_DIV_INIT: begin
            count_ff <= 5'(orpg_pkg::DIV_BITS - 1);
            rem_ff   <= diff_ff[47:16];
            quot_ff  <= flags.sat ? 32'hFFFF_FFFF : {diff_ff[15:0], 16'h0000};
         end
         orpg_pkg::WB_DIV_STEP: begin
            count_ff <= count_ff - 5'd1;
            rem_ff   <= rem_in;
            quot_ff  <= {quot_ff[30:0], rem_ge};
         end
         orpg_pkg::WB_CURRENT:  held_current_ff  <= clamp_in;
         orpg_pkg::WB_VOLTAGE:  held_voltage_ff  <= clamp_in;
         orpg_pkg::WB_VELOCITY: held_velocity_ff <= clamp_in;
         orpg_pkg::WB_PART:     part_ff          <= mul_ff[31:0];
         orpg_pkg::WB_PUBLISH: begin
            if (publish) begin
               held_phase_ff <= phase_in;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

@@ rtl/open_loop_ramp_phase_generator_unit.sv @@
// Top level of the open-loop ramp phase generator: ports, registers and response buffer.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  orpg_pkg::req_type (action, timestamp)
//   rsp       out        rsp_valid/rsp_ready  orpg_pkg::rsp_type (current, voltage, velocity, phase)
//   csr       in         csr_wen              csr_index (3 bits), csr_wdata (32 bits)
//
// An update's response follows acceptance once the radix-2 divider that forms dt has run
// 32 steps and the shared multiplier has done six products in sequence. When dt saturates
// the divider is skipped. A clear request yields no response. req_ready is high only while
// the sequencer waits for a request, from the cycle after publish; a stalled response holds
// the sequencer at its publish step. Reset is synchronous.
module open_loop_ramp_phase_generator_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  orpg_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output orpg_pkg::rsp_type rsp_data,
   input  logic              csr_wen,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   orpg_pkg::cfg_type   cfg_ff;
   orpg_pkg::ctrl_type  ctrl;
   orpg_pkg::stat_type  stat;
   orpg_pkg::flags_type flags;
   orpg_pkg::rsp_type   result;
   orpg_pkg::rsp_type   rsp_data_ff;
   logic                rsp_valid_ff;
   logic                accept;
   logic                out_busy;
   logic                publish;

   assign req_ready = ctrl.wait_req;
   assign accept    = req_valid && req_ready;
   assign out_busy  = rsp_valid_ff && !rsp_ready;
   assign publish   = (ctrl.wb == orpg_pkg::WB_PUBLISH) && !out_busy;

   assign stat.update   = accept && (req_data.action == orpg_pkg::ACTION_UPDATE);
   assign stat.sat      = flags.sat;
   assign stat.div_more = flags.div_more;
   assign stat.out_busy = out_busy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.current_goal  <= '0;
         cfg_ff.voltage_goal  <= '0;
         cfg_ff.velocity_goal <= '0;
         cfg_ff.current_slew  <= '0;
         cfg_ff.voltage_slew  <= '0;
         cfg_ff.velocity_slew <= '0;
         cfg_ff.start_phase   <= '0;
         cfg_ff.tick_rate     <= orpg_pkg::TICK_RATE_RESET;
      end else if (csr_wen) begin
         unique case (orpg_pkg::reg_index_type'(csr_index))
            orpg_pkg::REG_CURRENT_GOAL:  cfg_ff.current_goal  <= csr_wdata;
            orpg_pkg::REG_VOLTAGE_GOAL:  cfg_ff.voltage_goal  <= csr_wdata;
            orpg_pkg::REG_VELOCITY_GOAL: cfg_ff.velocity_goal <= csr_wdata;
            orpg_pkg::REG_CURRENT_SLEW:  cfg_ff.current_slew  <= csr_wdata[30:0];
            orpg_pkg::REG_VOLTAGE_SLEW:  cfg_ff.voltage_slew  <= csr_wdata[30:0];
            orpg_pkg::REG_VELOCITY_SLEW: cfg_ff.velocity_slew <= csr_wdata[30:0];
            orpg_pkg::REG_START_PHASE:   cfg_ff.start_phase   <= csr_wdata;
            orpg_pkg::REG_TICK_RATE:     cfg_ff.tick_rate     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // response buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (publish) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   orpg_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   orpg_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .ctrl     (ctrl),
      .accept   (accept),
      .req      (req_data),
      .out_busy (out_busy),
      .flags    (flags),
      .result   (result)
   );

endmodule
